FILE: rtl/cpd_pkg.sv
// ============================================================================
// cpd_pkg
// Shared sizes, types and codes for the closest pair distance block.
// ============================================================================
package cpd_pkg;

  // Capacity and coordinate format
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;

  // Result format
  localparam int SQ_W      = 36;
  localparam int FRAC_BITS = 8;
  localparam int RAD_W     = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

  // Index and count widths
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // Distance datapath widths
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int EXT_W  = (SUM_W > SQ_W) ? SUM_W : SQ_W;

  // Front-to-back queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // What the back end does with a point
  typedef enum logic {
    PT_STORE,
    PT_DROP
  } pt_kind_t;

  typedef struct packed {
    coord_t             x;
    coord_t             y;
    pt_kind_t           kind;
    logic               last;
    logic [IDX_W-1:0]   addr;
    logic [CNT_W-1:0]   n;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_RESULT
  } back_state_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

FILE: rtl/closest_pair_distance.sv
// ============================================================================
// closest_pair_distance
// Smallest distance between any two points of a 2D integer point set.
// ============================================================================
// Usage:
//   Send one point per input item on in_*; in_last_point marks the final
//   point of a set (it is a point of the set too). One result item follows
//   each set on out_*: exact squared distance, floor(distance * 256), a
//   no_pair flag for sets under two points and an overflowed flag when
//   points past the 64-entry capacity were dropped.
//   Points enter a four-item queue at one per cycle while it has room;
//   in_stall rises only when the queue is full.
//   After the last point leaves the queue, the pair scan runs one pair per
//   cycle over the n*(n-1)/2 pairs of n points; then the pipeline drains,
//   the square root is started and computes one bit per cycle with a done
//   strobe, and the result is registered.
//   The result register holds its item while out_stall is high; the queue
//   keeps taking points and the next set is loaded and scanned, but its
//   result waits in the back end until the register frees.
//   Reset (rst_n low, synchronous) empties the queue and clears the set.
// ============================================================================
module closest_pair_distance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cpd_pkg::IN_W-1:0]     in_point_x,
  input  logic signed [cpd_pkg::IN_W-1:0]     in_point_y,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cpd_pkg::SQ_W-1:0]            out_min_dist_sq,
  output logic [cpd_pkg::ROOT_W-1:0]          out_min_dist_root,
  output logic                                out_no_pair,
  output logic                                out_overflowed
);

  logic              q_full, q_push, q_pop, q_vld;
  cpd_pkg::q_entry_t push_entry, head_entry;

  // Accept and classify
  cpd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_last_point (in_last_point),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  // Decoupling queue
  cpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_vld   (q_vld),
    .head_entry (head_entry)
  );

  // Store, scan and result
  cpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (q_vld),
    .q_entry           (head_entry),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_min_dist_sq   (out_min_dist_sq),
    .out_min_dist_root (out_min_dist_root),
    .out_no_pair       (out_no_pair),
    .out_overflowed    (out_overflowed)
  );

endmodule

FILE: rtl/cpd_front.sv
// ============================================================================
// cpd_front
// Input side: accepts points, casts coordinates to the coordinate type and tags each item as a
// store or a drop with its memory slot and the running set size.
// ============================================================================
module cpd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [cpd_pkg::IN_W-1:0] in_point_x,
  input  logic signed [cpd_pkg::IN_W-1:0] in_point_y,
  input  logic                    in_last_point,
  input  logic                    q_full,
  output logic                    q_push,
  output cpd_pkg::q_entry_t       q_entry
);

  logic [cpd_pkg::CNT_W-1:0] count_r;
  logic [cpd_pkg::CNT_W-1:0] count_nxt;
  logic                      fits;

  // Handshake: stall only on a full queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign fits     = count_r < cpd_pkg::CNT_W'(cpd_pkg::MAX_POINTS);

  // Classify the item
  always_comb begin
    q_entry.x    = cpd_pkg::coord_t'(in_point_x);
    q_entry.y    = cpd_pkg::coord_t'(in_point_y);
    q_entry.last = in_last_point;
    q_entry.addr = count_r[cpd_pkg::IDX_W-1:0];
    if (fits) begin
      q_entry.kind = cpd_pkg::PT_STORE;
      q_entry.n    = count_r + cpd_pkg::CNT_W'(1);
    end else begin
      q_entry.kind = cpd_pkg::PT_DROP;
      q_entry.n    = count_r;
    end
    count_nxt = in_last_point ? '0 : q_entry.n;
  end

  // Running set size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/cpd_queue.sv
// ============================================================================
// cpd_queue
// Small FIFO of classified items between the front and the back end.
// ============================================================================
module cpd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cpd_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_vld,
  output cpd_pkg::q_entry_t head_entry
);

  cpd_pkg::q_entry_t              slot_r [cpd_pkg::Q_DEPTH];
  logic [cpd_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [cpd_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [cpd_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                           do_push;
  logic                           do_pop;

  assign full       = cnt_r == cpd_pkg::Q_CNT_W'(cpd_pkg::Q_DEPTH);
  assign head_vld   = cnt_r != '0;
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_vld;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + cpd_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + cpd_pkg::Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + cpd_pkg::Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - cpd_pkg::Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/cpd_sqrt.sv
// ============================================================================
// cpd_sqrt
// Iterative integer square root, one result bit per cycle.
// ============================================================================
module cpd_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  cpd_pkg::sqrt_req_t req,
  output cpd_pkg::sqrt_rsp_t rsp
);

  logic [cpd_pkg::RAD_W-1:0]      rad_r;
  logic [cpd_pkg::REM_W-1:0]      rem_r;
  logic [cpd_pkg::ROOT_W-1:0]     root_r;
  logic [cpd_pkg::SQRT_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [cpd_pkg::REM_W-1:0]      rem_sh;
  logic [cpd_pkg::REM_W-1:0]      trial;
  logic                           fit;

  // One digit step: bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem_r[cpd_pkg::REM_W-3:0], rad_r[cpd_pkg::RAD_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    fit    = rem_sh >= trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + cpd_pkg::SQRT_CNT_W'(1);
        if (cnt_r == cpd_pkg::SQRT_CNT_W'(cpd_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[cpd_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fit ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[cpd_pkg::ROOT_W-2:0], fit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

FILE: rtl/cpd_back.sv
// ============================================================================
// cpd_back
// Back end: writes points to the store, scans all pairs one per cycle,
// takes the root of the minimum and holds the result for the receiver.
// ============================================================================
module cpd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_vld,
  input  cpd_pkg::q_entry_t             q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpd_pkg::SQ_W-1:0]      out_min_dist_sq,
  output logic [cpd_pkg::ROOT_W-1:0]    out_min_dist_root,
  output logic                          out_no_pair,
  output logic                          out_overflowed
);

  cpd_pkg::back_state_t state_r;
  cpd_pkg::back_state_t state_nxt;

  // Point store
  cpd_pkg::coord_t x_mem [cpd_pkg::MAX_POINTS];
  cpd_pkg::coord_t y_mem [cpd_pkg::MAX_POINTS];
  cpd_pkg::coord_t xa_r, ya_r, xb_r, yb_r;

  // Scan control
  logic [cpd_pkg::IDX_W-1:0] i_r, j_r, last_idx;
  logic [cpd_pkg::CNT_W-1:0] n_r;
  logic                      dropped_r, ovf_r, no_pair_r;
  logic                      issue, scan_end;

  // Pair pipeline
  logic                           s1_vld_r, s2_vld_r, s3_vld_r;
  logic [cpd_pkg::COORD_BITS:0]   dxw, dyw, dxa, dya;
  logic [cpd_pkg::COORD_BITS-1:0] dx_r, dy_r;
  logic [cpd_pkg::PROD_W-1:0]     sqx_r, sqy_r;
  logic [cpd_pkg::SUM_W-1:0]      sum, best_r;
  logic                           best_vld_r;

  // Result shaping
  logic [cpd_pkg::EXT_W-1:0]  best_ext;
  logic                       sq_sat;
  logic [cpd_pkg::SQ_W-1:0]   sq_clip;
  logic [cpd_pkg::ROOT_W-1:0] root_val;
  cpd_pkg::sqrt_req_t         sqrt_req;
  cpd_pkg::sqrt_rsp_t         sqrt_rsp;
  logic                       sqrt_start, out_load;

  logic                       out_vld_r;
  logic [cpd_pkg::SQ_W-1:0]   out_sq_r;
  logic [cpd_pkg::ROOT_W-1:0] out_root_r;
  logic                       out_np_r, out_ovf_r;

  assign last_idx = cpd_pkg::IDX_W'(n_r - cpd_pkg::CNT_W'(1));
  assign scan_end = (i_r == last_idx - cpd_pkg::IDX_W'(1)) && (j_r == last_idx);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpd_pkg::ST_IDLE: begin
        if (q_vld && q_entry.last) begin
          state_nxt = (q_entry.n < cpd_pkg::CNT_W'(2)) ? cpd_pkg::ST_RESULT
                                                        : cpd_pkg::ST_SCAN;
        end
      end
      cpd_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = cpd_pkg::ST_DRAIN;
      end
      cpd_pkg::ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) state_nxt = cpd_pkg::ST_ROOT_GO;
      end
      cpd_pkg::ST_ROOT_GO: begin
        state_nxt = cpd_pkg::ST_ROOT_WAIT;
      end
      cpd_pkg::ST_ROOT_WAIT: begin
        if (sqrt_rsp.done) state_nxt = cpd_pkg::ST_RESULT;
      end
      cpd_pkg::ST_RESULT: begin
        if (out_load) state_nxt = cpd_pkg::ST_IDLE;
      end
      default: state_nxt = cpd_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop      = 1'b0;
    issue      = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      cpd_pkg::ST_IDLE:    q_pop      = q_vld;
      cpd_pkg::ST_SCAN:    issue      = 1'b1;
      cpd_pkg::ST_ROOT_GO: sqrt_start = 1'b1;
      cpd_pkg::ST_RESULT:  out_load   = !out_vld_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store write and dual registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_entry.kind == cpd_pkg::PT_STORE) begin
      x_mem[q_entry.addr] <= q_entry.x;
      y_mem[q_entry.addr] <= q_entry.y;
    end
    xa_r <= x_mem[i_r];
    ya_r <= y_mem[i_r];
    xb_r <= x_mem[j_r];
    yb_r <= y_mem[j_r];
  end

  // Set bookkeeping and pair walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropped_r <= 1'b0;
      ovf_r     <= 1'b0;
      no_pair_r <= 1'b0;
      n_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      if (q_pop) begin
        if (q_entry.last) begin
          dropped_r <= 1'b0;
          ovf_r     <= dropped_r || (q_entry.kind == cpd_pkg::PT_DROP);
          no_pair_r <= q_entry.n < cpd_pkg::CNT_W'(2);
          n_r       <= q_entry.n;
          i_r       <= '0;
          j_r       <= cpd_pkg::IDX_W'(1);
        end else if (q_entry.kind == cpd_pkg::PT_DROP) begin
          dropped_r <= 1'b1;
        end
      end else if (issue && !scan_end) begin
        if (j_r == last_idx) begin
          i_r <= i_r + cpd_pkg::IDX_W'(1);
          j_r <= i_r + cpd_pkg::IDX_W'(2);
        end else begin
          j_r <= j_r + cpd_pkg::IDX_W'(1);
        end
      end
    end
  end

  // Absolute coordinate differences and the sum of squares
  always_comb begin
    dxw = {xa_r[cpd_pkg::COORD_BITS-1], xa_r} - {xb_r[cpd_pkg::COORD_BITS-1], xb_r};
    dyw = {ya_r[cpd_pkg::COORD_BITS-1], ya_r} - {yb_r[cpd_pkg::COORD_BITS-1], yb_r};
    dxa = dxw[cpd_pkg::COORD_BITS] ? (~dxw) + (cpd_pkg::COORD_BITS+1)'(1) : dxw;
    dya = dyw[cpd_pkg::COORD_BITS] ? (~dyw) + (cpd_pkg::COORD_BITS+1)'(1) : dyw;
    sum = cpd_pkg::SUM_W'(sqx_r) + cpd_pkg::SUM_W'(sqy_r);
  end

  // Pipeline valids and running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (q_pop && q_entry.last) begin
        best_vld_r <= 1'b0;
      end else if (s3_vld_r && (!best_vld_r || sum < best_r)) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  // Pipeline data
  always_ff @(posedge clk) begin
    dx_r  <= dxa[cpd_pkg::COORD_BITS-1:0];
    dy_r  <= dya[cpd_pkg::COORD_BITS-1:0];
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    if (s3_vld_r && (!best_vld_r || sum < best_r)) begin
      best_r <= sum;
    end
  end

  // Saturate to the output range and take the root
  always_comb begin
    best_ext = cpd_pkg::EXT_W'(best_r);
    sq_sat   = best_ext > cpd_pkg::EXT_W'({cpd_pkg::SQ_W{1'b1}});
    sq_clip  = sq_sat ? {cpd_pkg::SQ_W{1'b1}} : cpd_pkg::SQ_W'(best_r);
    root_val = sq_sat ? {cpd_pkg::ROOT_W{1'b1}} : sqrt_rsp.root;
    sqrt_req.start = sqrt_start;
    sqrt_req.rad   = {sq_clip, {(2 * cpd_pkg::FRAC_BITS){1'b0}}};
  end

  cpd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sq_r   <= no_pair_r ? '0 : sq_clip;
      out_root_r <= no_pair_r ? '0 : root_val;
      out_np_r   <= no_pair_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_min_dist_sq   = out_sq_r;
  assign out_min_dist_root = out_root_r;
  assign out_no_pair       = out_np_r;
  assign out_overflowed    = out_ovf_r;

endmodule
